// ----- hdl/srd_pkg.sv -----
// Shared types and constants of the scan record deframer.
`default_nettype none
package srd_pkg;

	localparam int unsigned LimW = 18;
	localparam int unsigned PreW = 17;
	localparam int unsigned LenW = 16;

	localparam logic [LimW-1:0] LIM_RESET = 18'd131075;
	localparam logic [LimW-1:0] LIM_MIN_DATA = 18'd3;

	localparam logic [7:0] STATUS_SINGLE = 8'h80;
	localparam logic [7:0] STATUS_ABOVE = 8'hC1;
	localparam logic [PreW-1:0] PREFIX_OVERHEAD = 17'd5;
	localparam logic [LimW-1:0] PREFIX_ERR_LEN = 18'd3;
	localparam logic [LimW-1:0] ONE_BYTE_LEN = 18'd1;

	// Byte kind codes as seen on the result channel.
	localparam logic [2:0] KIND_STATUS = 3'd0;
	localparam logic [2:0] KIND_HEADER = 3'd1;
	localparam logic [2:0] KIND_WLEN = 3'd2;
	localparam logic [2:0] KIND_WRAPPER = 3'd3;
	localparam logic [2:0] KIND_PLEN = 3'd4;
	localparam logic [2:0] KIND_PAYLOAD = 3'd5;

	typedef enum logic [6:0] {
		PH_HEADER  = 7'b0000001,
		PH_WLEN_LO = 7'b0000010,
		PH_WLEN_HI = 7'b0000100,
		PH_WRAPPER = 7'b0001000,
		PH_PLEN_LO = 7'b0010000,
		PH_PLEN_HI = 7'b0100000,
		PH_PAYLOAD = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [7:0]      out_byte;
		logic [2:0]      byte_kind;
		logic            end_of_record;
		logic            length_error;
		logic [LimW-1:0] record_length;
		logic [PreW-1:0] prefix_length;
		logic [LenW-1:0] payload_length;
	} result_t;

endpackage
`default_nettype wire

// ----- hdl/srd_stream_if.sv -----
// Input byte channel of the scan record deframer.
`default_nettype none
interface srd_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

// ----- hdl/srd_record_if.sv -----
// Result channel of the scan record deframer: each byte with its record annotations.
`default_nettype none
interface srd_record_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [2:0]  byte_kind;
	logic        end_of_record;
	logic        length_error;
	logic [17:0] record_length;
	logic [16:0] prefix_length;
	logic [15:0] payload_length;

	modport source (output valid, output out_byte, output byte_kind, output end_of_record,
		output length_error, output record_length, output prefix_length,
		output payload_length, input ready);
	modport sink (input valid, input out_byte, input byte_kind, input end_of_record,
		input length_error, input record_length, input prefix_length,
		input payload_length, output ready);
endinterface
`default_nettype wire

// ----- hdl/scan_record_deframer_top.sv -----
// Scan record deframer: annotates a scanner byte stream with record structure.
// The block takes one byte per clock and returns one annotated item per byte, in the
// cycle after it is accepted, from a single output register. The phase machine and the
// length counters update in the cycle a byte is taken, and the input is ready whenever
// the output register is empty or is being emptied. The user must write the record
// length limit (cfg_we/cfg_wdata) only while the stream is idle; it is not enforced.
`default_nettype none
module scan_record_deframer_top
	import srd_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	srd_stream_if.sink           stream,
	srd_record_if.source         records,
	input  wire logic            cfg_we,
	input  wire logic [LimW-1:0] cfg_wdata
);

	logic [LimW-1:0] lim_q;
	phase_t          phase_q, phase_n;
	logic [LenW-1:0] wlen_q, wlen_n;
	logic [7:0]      low_q, low_n;
	logic [LenW-1:0] remain_q, remain_n;
	logic [LenW-1:0] pcount_q, pcount_n;
	logic            out_valid_q;
	result_t         out_q, res;

	logic            accept;
	logic [7:0]      b;
	logic [PreW-1:0] pre;
	logic [LenW-1:0] len_word;
	logic [PreW-1:0] pre_new;
	logic [LimW-1:0] total;
	logic            status;

	assign stream.ready = !out_valid_q || records.ready;
	assign accept = stream.valid && stream.ready;
	assign b = stream.data_byte;

	assign pre = {1'b0, wlen_q} + PREFIX_OVERHEAD;
	assign len_word = {b, low_q};
	assign pre_new = {1'b0, len_word} + PREFIX_OVERHEAD;
	assign total = {1'b0, pre} + {2'b00, len_word};
	assign status = (b == STATUS_SINGLE) || (b > STATUS_ABOVE);

	always_comb begin
		phase_n = phase_q;
		wlen_n = wlen_q;
		low_n = low_q;
		remain_n = remain_q;
		pcount_n = pcount_q;
		res = '0;
		res.out_byte = b;
		case (phase_q)
			PH_WLEN_LO: begin
				low_n = b;
				res.byte_kind = KIND_WLEN;
				phase_n = PH_WLEN_HI;
			end
			PH_WLEN_HI: begin
				wlen_n = len_word;
				res.byte_kind = KIND_WLEN;
				res.prefix_length = pre_new;
				if ({1'b0, pre_new} > lim_q) begin
					res.end_of_record = 1'b1;
					res.length_error = 1'b1;
					res.record_length = PREFIX_ERR_LEN;
					phase_n = PH_HEADER;
				end else begin
					remain_n = len_word;
					phase_n = (len_word == '0) ? PH_PLEN_LO : PH_WRAPPER;
				end
			end
			PH_WRAPPER: begin
				res.byte_kind = KIND_WRAPPER;
				res.prefix_length = pre;
				remain_n = remain_q - 1'b1;
				if (remain_n == '0) begin
					phase_n = PH_PLEN_LO;
				end
			end
			PH_PLEN_LO: begin
				low_n = b;
				res.byte_kind = KIND_PLEN;
				res.prefix_length = pre;
				phase_n = PH_PLEN_HI;
			end
			PH_PLEN_HI: begin
				pcount_n = len_word;
				res.byte_kind = KIND_PLEN;
				res.prefix_length = pre;
				if (total > lim_q) begin
					res.end_of_record = 1'b1;
					res.length_error = 1'b1;
					res.record_length = {1'b0, pre};
					res.payload_length = len_word;
					phase_n = PH_HEADER;
				end else if (len_word == '0) begin
					res.end_of_record = 1'b1;
					res.record_length = total;
					phase_n = PH_HEADER;
				end else begin
					res.payload_length = len_word;
					remain_n = len_word;
					phase_n = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				res.byte_kind = KIND_PAYLOAD;
				res.prefix_length = pre;
				res.payload_length = pcount_q;
				remain_n = remain_q - 1'b1;
				if (remain_n == '0) begin
					res.end_of_record = 1'b1;
					res.record_length = {1'b0, pre} + {2'b00, pcount_q};
					phase_n = PH_HEADER;
				end
			end
			default: begin
				// Header byte; any code outside the machine is treated the same way.
				wlen_n = '0;
				pcount_n = '0;
				remain_n = '0;
				res.byte_kind = status ? KIND_STATUS : KIND_HEADER;
				if (lim_q == '0) begin
					res.end_of_record = 1'b1;
					res.length_error = 1'b1;
					res.record_length = ONE_BYTE_LEN;
					phase_n = PH_HEADER;
				end else if (status) begin
					res.end_of_record = 1'b1;
					res.record_length = ONE_BYTE_LEN;
					phase_n = PH_HEADER;
				end else if (lim_q < LIM_MIN_DATA) begin
					res.end_of_record = 1'b1;
					res.length_error = 1'b1;
					res.record_length = ONE_BYTE_LEN;
					phase_n = PH_HEADER;
				end else begin
					phase_n = PH_WLEN_LO;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LIM_RESET;
			phase_q <= PH_HEADER;
			wlen_q <= '0;
			low_q <= '0;
			remain_q <= '0;
			pcount_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				lim_q <= cfg_wdata;
			end
			if (accept) begin
				phase_q <= phase_n;
				wlen_q <= wlen_n;
				low_q <= low_n;
				remain_q <= remain_n;
				pcount_q <= pcount_n;
				out_valid_q <= 1'b1;
			end else if (records.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

	assign records.valid = out_valid_q;
	assign records.out_byte = out_q.out_byte;
	assign records.byte_kind = out_q.byte_kind;
	assign records.end_of_record = out_q.end_of_record;
	assign records.length_error = out_q.length_error;
	assign records.record_length = out_q.record_length;
	assign records.prefix_length = out_q.prefix_length;
	assign records.payload_length = out_q.payload_length;

`ifndef ASSERT_OFF
	a_err_ends_record: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid && records.length_error |-> records.end_of_record)
		else $error("length error without end of record");

	a_status_one_byte: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (phase_q == PH_HEADER) && status |=>
		records.valid && records.end_of_record && (records.byte_kind == KIND_STATUS))
		else $error("status byte did not close a one-byte record");

	a_len_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid && !records.end_of_record |-> (records.record_length == '0))
		else $error("record length shown before end of record");
`endif

endmodule
`default_nettype wire
